### src/mlemsp_pkg.sv
`default_nettype none
package mlemsp_pkg;

    // command codes
    localparam logic [2:0] CMD_WRITE  = 3'd0;
    localparam logic [2:0] CMD_FWD    = 3'd1;
    localparam logic [2:0] CMD_BACK   = 3'd2;
    localparam logic [2:0] CMD_CLEAR  = 3'd3;
    localparam logic [2:0] CMD_UPDATE = 3'd4;
    localparam logic [2:0] CMD_READ   = 3'd5;

    // result kinds
    localparam logic KIND_ROW   = 1'b0;
    localparam logic KIND_VOXEL = 1'b1;

    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_RD,
        ST_MUL,
        ST_EXEC,
        ST_DIV,
        ST_EMIT
    } state_t;

endpackage
`default_nettype wire

### src/mlemsp_if.sv
`default_nettype none
interface mlemsp_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [15:0] voxel_index;
    logic [31:0] value;
    logic [15:0] weight;
    logic        row_last;

    modport source (output valid, command, voxel_index, value, weight, row_last,
                    input ready);
    modport sink   (input valid, command, voxel_index, value, weight, row_last,
                    output ready);
endinterface

interface mlemsp_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [31:0] projection;
    logic [31:0] ratio;
    logic [31:0] voxel_value;
    logic [31:0] accum_value;

    modport source (output valid, result_kind, projection, ratio, voxel_value,
                    accum_value, input ready);
    modport sink   (input valid, result_kind, projection, ratio, voxel_value,
                    accum_value, output ready);
endinterface
`default_nettype wire

### src/mlemsp_ram.sv
`default_nettype none
module mlemsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### src/mlemsp_div.sv
`default_nettype none
module mlemsp_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] num,
    input  wire logic [47:0] den,
    output logic             done,
    output logic [31:0]      quo
);

    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [48:0] rem_reg, rem_next;
    logic [63:0] q_reg, q_next;
    logic [47:0] den_reg, den_next;
    logic [48:0] rem_sh;
    logic [49:0] diff;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        rem_sh    = {rem_reg[47:0], q_reg[63]};
        diff      = {1'b0, rem_sh} - {2'b0, den_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            rem_next  = 49'd0;
            q_next    = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            if (!diff[49])
            begin
                rem_next = diff[48:0];
                q_next   = {q_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                q_next   = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_next;
    end

    // pulse done in the cycle after the last step, saturate the quotient
    logic done_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 6'd63) && !start;
        end
    end

    assign done = done_reg;
    assign quo  = (|q_reg[63:32]) ? mlemsp_pkg::MAX32 : q_reg[31:0];

endmodule
`default_nettype wire

### src/mlem_sparse_projector.sv
`default_nettype none
// Write, clear, back element and forward element without row end pass through the
// read, multiply and exec states and return to idle. Read voxel, and a row end with zero
// measured count or zero projection, go from exec to emit and the output register. Row
// end and voxel update also wait in the div state on the shared 64-step restoring divider.
// One item at a time; the output register lets the next item in while a result waits.
// Reset: row sum clears at once; the accumulator store is swept to zero, one entry a
// cycle, over all VOXELS entries, with no item accepted meanwhile.
module mlem_sparse_projector #(
    parameter int VOXELS = 65536
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    mlemsp_in_if.sink    items,
    mlemsp_out_if.source results
);

    localparam int AW = $clog2(VOXELS);
    localparam logic [31:0] VOX_LIM  = 32'(VOXELS);
    localparam logic [AW-1:0] CLR_LAST = AW'(VOXELS - 1);

    mlemsp_pkg::state_t state_reg, state_next;

    logic [AW-1:0] clr_cnt_reg;
    logic [2:0]    cmd_reg;
    logic [15:0]   idx_reg;
    logic [31:0]   val_reg;
    logic [15:0]   w_reg;
    logic          last_reg;
    logic          ok_reg;
    logic [31:0]   vox_reg, acc_reg;
    logic [63:0]   prod_reg;
    logic [47:0]   row_sum_reg, row_sum_next;
    logic          res_kind_reg;
    logic [31:0]   res_ratio_reg, res_vox_reg, res_acc_reg;
    logic          out_valid_reg;
    logic          out_kind_reg;
    logic [31:0]   out_proj_reg, out_ratio_reg, out_vox_reg, out_acc_reg;

    logic [AW-1:0] addr;
    logic [31:0]   idx32;
    logic          ok_in;
    logic [31:0]   vox_rd, acc_rd;
    logic [31:0]   vox_eff, acc_eff;
    logic          vox_we, acc_we;
    logic [31:0]   vox_wdata, acc_wdata;
    logic [AW-1:0] acc_waddr;
    logic [48:0]   fwd_sum;
    logic [47:0]   fwd_sat;
    logic [32:0]   back_sum;
    logic [31:0]   back_sat;
    logic          div_start, div_done;
    logic [63:0]   div_num;
    logic [47:0]   div_den;
    logic [31:0]   div_quo;
    logic          accept, out_free;
    logic [31:0]   mul_a, mul_b;

    assign idx32  = {16'd0, items.voxel_index};
    assign ok_in  = idx32 < VOX_LIM;
    assign addr   = AW'({16'd0, idx_reg});
    assign accept = items.valid && items.ready;
    assign out_free = !out_valid_reg || results.ready;

    mlemsp_ram #(.WIDTH(32), .DEPTH(VOXELS)) u_vox_ram (
        .clk   (clk),
        .we    (vox_we),
        .waddr (addr),
        .wdata (vox_wdata),
        .raddr (addr),
        .rdata (vox_rd)
    );

    mlemsp_ram #(.WIDTH(32), .DEPTH(VOXELS)) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .raddr (addr),
        .rdata (acc_rd)
    );

    mlemsp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // datapath helpers
    always_comb
    begin
        vox_eff  = ok_reg ? vox_rd : 32'd0;
        acc_eff  = ok_reg ? acc_rd : 32'd0;
        mul_a    = (cmd_reg == mlemsp_pkg::CMD_BACK) ? val_reg : vox_eff;
        mul_b    = (cmd_reg == mlemsp_pkg::CMD_UPDATE) ? acc_eff : {16'd0, w_reg};
        fwd_sum  = {1'b0, row_sum_reg} + {1'b0, prod_reg[47:0]};
        fwd_sat  = fwd_sum[48] ? mlemsp_pkg::MAX48 : fwd_sum[47:0];
        back_sum = {1'b0, acc_reg} + {1'b0, prod_reg[47:16]};
        back_sat = back_sum[32] ? mlemsp_pkg::MAX32 : back_sum[31:0];
        if (cmd_reg == mlemsp_pkg::CMD_FWD)
        begin
            div_num = {val_reg, 32'd0};
            div_den = fwd_sat;
        end
        else
        begin
            div_num = prod_reg;
            div_den = {16'd0, (val_reg != 32'd0) ? val_reg : 32'd1};
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mlemsp_pkg::ST_CLR:
            begin
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = mlemsp_pkg::ST_IDLE;
                end
            end
            mlemsp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = mlemsp_pkg::ST_RD;
                end
            end
            mlemsp_pkg::ST_RD:
            begin
                state_next = mlemsp_pkg::ST_MUL;
            end
            mlemsp_pkg::ST_MUL:
            begin
                state_next = mlemsp_pkg::ST_EXEC;
            end
            mlemsp_pkg::ST_EXEC:
            begin
                case (cmd_reg)
                    mlemsp_pkg::CMD_FWD:
                    begin
                        if (!last_reg)
                        begin
                            state_next = mlemsp_pkg::ST_IDLE;
                        end
                        else if (val_reg == 32'd0 || fwd_sat == 48'd0)
                        begin
                            state_next = mlemsp_pkg::ST_EMIT;
                        end
                        else
                        begin
                            state_next = mlemsp_pkg::ST_DIV;
                        end
                    end
                    mlemsp_pkg::CMD_UPDATE: state_next = mlemsp_pkg::ST_DIV;
                    mlemsp_pkg::CMD_READ:   state_next = mlemsp_pkg::ST_EMIT;
                    default:                state_next = mlemsp_pkg::ST_IDLE;
                endcase
            end
            mlemsp_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = mlemsp_pkg::ST_EMIT;
                end
            end
            mlemsp_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = mlemsp_pkg::ST_IDLE;
                end
            end
            default: state_next = mlemsp_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        items.ready = 1'b0;
        vox_we      = 1'b0;
        vox_wdata   = val_reg;
        acc_we      = 1'b0;
        acc_waddr   = addr;
        acc_wdata   = 32'd0;
        div_start   = 1'b0;
        unique case (state_reg)
            mlemsp_pkg::ST_CLR:
            begin
                acc_we    = 1'b1;
                acc_waddr = clr_cnt_reg;
            end
            mlemsp_pkg::ST_IDLE:
            begin
                items.ready = 1'b1;
            end
            mlemsp_pkg::ST_EXEC:
            begin
                case (cmd_reg)
                    mlemsp_pkg::CMD_WRITE:
                    begin
                        vox_we = ok_reg;
                    end
                    mlemsp_pkg::CMD_BACK:
                    begin
                        acc_we    = ok_reg && (val_reg != 32'd0);
                        acc_wdata = back_sat;
                    end
                    mlemsp_pkg::CMD_CLEAR:
                    begin
                        acc_we = ok_reg;
                    end
                    mlemsp_pkg::CMD_FWD:
                    begin
                        div_start = last_reg && (val_reg != 32'd0) && (fwd_sat != 48'd0);
                    end
                    mlemsp_pkg::CMD_UPDATE:
                    begin
                        div_start = 1'b1;
                    end
                    default:
                    begin
                        div_start = 1'b0;
                    end
                endcase
            end
            mlemsp_pkg::ST_DIV:
            begin
                vox_we    = div_done && ok_reg && (cmd_reg == mlemsp_pkg::CMD_UPDATE);
                vox_wdata = div_quo;
            end
            default:
            begin
                items.ready = 1'b0;
            end
        endcase
    end

    // row sum: accumulate in exec, clear on row result
    always_comb
    begin
        row_sum_next = row_sum_reg;
        if (state_reg == mlemsp_pkg::ST_EXEC && cmd_reg == mlemsp_pkg::CMD_FWD)
        begin
            row_sum_next = fwd_sat;
        end
        else if (state_reg == mlemsp_pkg::ST_EMIT && out_free
                 && res_kind_reg == mlemsp_pkg::KIND_ROW)
        begin
            row_sum_next = 48'd0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mlemsp_pkg::ST_CLR;
            clr_cnt_reg   <= '0;
            row_sum_reg   <= 48'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            row_sum_reg <= row_sum_next;
            if (state_reg == mlemsp_pkg::ST_CLR)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (state_reg == mlemsp_pkg::ST_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= items.command;
            idx_reg  <= items.voxel_index;
            val_reg  <= items.value;
            w_reg    <= items.weight;
            last_reg <= items.row_last;
            ok_reg   <= ok_in;
        end
        if (state_reg == mlemsp_pkg::ST_MUL)
        begin
            vox_reg  <= vox_eff;
            acc_reg  <= acc_eff;
            prod_reg <= 64'(mul_a) * 64'(mul_b);
        end
        if (state_reg == mlemsp_pkg::ST_EXEC)
        begin
            res_kind_reg  <= (cmd_reg == mlemsp_pkg::CMD_FWD) ? mlemsp_pkg::KIND_ROW
                                                              : mlemsp_pkg::KIND_VOXEL;
            res_ratio_reg <= (val_reg == 32'd0) ? 32'd0 : mlemsp_pkg::MAX32;
            res_vox_reg   <= vox_reg;
            res_acc_reg   <= acc_reg;
        end
        if (state_reg == mlemsp_pkg::ST_DIV && div_done)
        begin
            if (cmd_reg == mlemsp_pkg::CMD_FWD)
            begin
                res_ratio_reg <= div_quo;
            end
            else
            begin
                res_vox_reg <= ok_reg ? div_quo : 32'd0;
            end
        end
        if (state_reg == mlemsp_pkg::ST_EMIT && out_free)
        begin
            out_kind_reg <= res_kind_reg;
            if (res_kind_reg == mlemsp_pkg::KIND_ROW)
            begin
                out_proj_reg  <= row_sum_reg[47:16];
                out_ratio_reg <= res_ratio_reg;
                out_vox_reg   <= 32'd0;
                out_acc_reg   <= 32'd0;
            end
            else
            begin
                out_proj_reg  <= 32'd0;
                out_ratio_reg <= 32'd0;
                out_vox_reg   <= res_vox_reg;
                out_acc_reg   <= res_acc_reg;
            end
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.result_kind = out_kind_reg;
    assign results.projection  = out_proj_reg;
    assign results.ratio       = out_ratio_reg;
    assign results.voxel_value = out_vox_reg;
    assign results.accum_value = out_acc_reg;

endmodule
`default_nettype wire
